[rtl/bilinear_grid_height_lookup_assert.svh]
// Assertion macros shared by the grid height lookup RTL.
// Depends on a clock named clock and a synchronous active-high reset named reset.
`ifndef BILINEAR_GRID_HEIGHT_LOOKUP_ASSERT_SVH
`define BILINEAR_GRID_HEIGHT_LOOKUP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define BGHL_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bilinear_grid_height_lookup: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define BGHL_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bilinear_grid_height_lookup: next-cycle check failed");

`endif

[rtl/bglk_pkg.sv]
// Shared types and constants of the bilinear grid height lookup.
// No dependencies; imported by the divider, the top module and the testbench.
`timescale 1ns / 1ps

package bglk_pkg;

   // Default grid dimensions.
   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   // Field widths.
   localparam int COORD_W = 32;
   localparam int HGT_W   = 24;
   localparam int SP_W    = 24;
   localparam int CNT_W   = 7;
   localparam int IDX_W   = 6;
   localparam int FRAC_W  = 8;
   localparam int CMP_W   = 40;

   // Register port.
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_SPACING  = 3'd2;
   localparam logic [2:0] REG_COLUMNS  = 3'd3;
   localparam logic [2:0] REG_ROWS     = 3'd4;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                       cmd;
      logic [IDX_W-1:0]           cell_row;
      logic [IDX_W-1:0]           cell_col;
      logic signed [HGT_W-1:0]    cell_height;
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
   } req_type;

   typedef struct packed {
      logic signed [HGT_W-1:0] height_out;
      logic                    inside_res;
   } rsp_type;

endpackage

[rtl/bglk_bank.sv]
// One bank of the height grid: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bglk_bank #(
   parameter int AW = 10,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [0:(2**AW)-1];
   logic [DW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port returns the old contents on a same-address write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bglk_div.sv]
// Pipelined restoring divider: one quotient bit per stage, integer and fraction.
// Depends on bglk_pkg for the spacing and fraction widths.
`timescale 1ns / 1ps

module bglk_div #(
   parameter int DXW = 30,
   parameter int IW  = 6
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [DXW-1:0]                       dividend,
   input  logic [bglk_pkg::SP_W-1:0]            divisor,
   output logic [IW+bglk_pkg::FRAC_W-1:0]       quotient
);
   import bglk_pkg::*;

   localparam int Q = IW + FRAC_W;

   logic [SP_W-1:0] rem_init;
   logic [Q-1:0]    nq_init;
   logic [SP_W-1:0] rem_ff [0:Q-2];
   logic [Q-1:0]    nq_ff  [0:Q-1];

   // The integer quotient is below 2**IW, so the top bits start below the divisor.
   assign rem_init = SP_W'(dividend >> IW);
   assign nq_init  = {dividend[IW-1:0], FRAC_W'(0)};

   genvar k;
   for (k = 0; k < Q; k++) begin : g_step
      logic [SP_W-1:0] rem_prev;
      logic [Q-1:0]    nq_prev;
      logic [SP_W:0]   trial;
      logic            ge;

      if (k == 0) begin : g_first
         assign rem_prev = rem_init;
         assign nq_prev  = nq_init;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
      end

      // Shift in one dividend bit and try a subtraction.
      assign trial = {rem_prev, nq_prev[Q-1]};
      assign ge    = (trial >= {1'b0, divisor});

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[k] <= {nq_prev[Q-2:0], ge};
         end
      end

      if (k < Q - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? SP_W'(trial - {1'b0, divisor}) : trial[SP_W-1:0];
            end
         end
      end
   end

   assign quotient = nq_ff[Q-1];

endmodule

[rtl/bilinear_grid_height_lookup.sv]
// Stages: accepted transaction, origin offsets and in-grid test, bit-per-stage divider pipeline,
// grid read, row blend products, row sums, column blend products, output. Throughput: one
// transaction per cycle while the skid register is empty; the four grid banks serve all corners at once.
// Reset clears all valid flags and loads the register reset values.
// Grid contents stay undefined until written; no clearing pass is run.
`timescale 1ns / 1ps
`include "bilinear_grid_height_lookup_assert.svh"

module bilinear_grid_height_lookup #(
   parameter int MAX_COLS = bglk_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = bglk_pkg::MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bglk_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bglk_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bglk_pkg::CSR_AW-1:0]   paddr,
   input  logic [bglk_pkg::CSR_DW-1:0]   pwdata,
   output logic [bglk_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import bglk_pkg::*;

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int IW  = (CW > RW) ? CW : RW;
   localparam int HCW = (CW > 1) ? CW - 1 : 1;
   localparam int HRW = (RW > 1) ? RW - 1 : 1;
   localparam int BAW = HRW + HCW;
   localparam int NCW = $clog2(MAX_COLS + 1);
   localparam int NRW = $clog2(MAX_ROWS + 1);
   localparam int NW  = (NCW > NRW) ? NCW : NRW;
   localparam int LW  = NW + SP_W;
   localparam int QW  = IW + FRAC_W;
   localparam int Q   = QW;

   typedef struct packed {
      logic                    query;
      logic                    in_grid;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [HGT_W-1:0] height;
   } side_type;

   // ---------------------------------------------------------------- registers
   logic signed [COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic [SP_W-1:0]           spacing_ff;
   logic [CNT_W-1:0]          columns_ff, rows_ff;
   logic                      csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         spacing_ff  <= SP_W'(256);
         columns_ff  <= CNT_W'(2);
         rows_ff     <= CNT_W'(2);
      end else if (csr_wr) begin
         case (paddr[4:2])
            REG_ORIGIN_X: origin_x_ff <= pwdata;
            REG_ORIGIN_Y: origin_y_ff <= pwdata;
            REG_SPACING:  spacing_ff  <= pwdata[SP_W-1:0];
            REG_COLUMNS:  columns_ff  <= pwdata[CNT_W-1:0];
            REG_ROWS:     rows_ff     <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (paddr[4:2])
         REG_ORIGIN_X: prdata = origin_x_ff;
         REG_ORIGIN_Y: prdata = origin_y_ff;
         REG_SPACING:  prdata = CSR_DW'(spacing_ff);
         REG_COLUMNS:  prdata = CSR_DW'(columns_ff);
         REG_ROWS:     prdata = CSR_DW'(rows_ff);
         default:      prdata = '0;
      endcase
   end

   // Effective spacing and grid counts, and the far-edge limits.
   logic [SP_W-1:0] sp_eff;
   logic [NW-1:0]   cols_eff, rows_eff;
   logic [LW-1:0]   lim_x_in, lim_y_in, lim_x_ff, lim_y_ff;

   assign sp_eff = (spacing_ff == '0) ? SP_W'(1) : spacing_ff;

   always_comb begin
      if (columns_ff < CNT_W'(2)) begin
         cols_eff = NW'(2);
      end else if (32'(columns_ff) > MAX_COLS) begin
         cols_eff = NW'(MAX_COLS);
      end else begin
         cols_eff = NW'(columns_ff);
      end
      if (rows_ff < CNT_W'(2)) begin
         rows_eff = NW'(2);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = NW'(MAX_ROWS);
      end else begin
         rows_eff = NW'(rows_ff);
      end
   end

   assign lim_x_in = LW'(cols_eff - NW'(1)) * LW'(sp_eff);
   assign lim_y_in = LW'(rows_eff - NW'(1)) * LW'(sp_eff);

   always_ff @(posedge clock) begin
      lim_x_ff <= lim_x_in;
      lim_y_ff <= lim_y_in;
   end

   // ---------------------------------------------------------------- flow control
   // The whole pipeline moves together; the skid register absorbs the last result.
   logic adv;
   logic skid_valid_ff;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage 1: accepted transaction.
   logic    p1_valid_ff;
   req_type p1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_req_ff <= req_data;
      end
   end

   // Stage 2: offsets from the origin and the in-grid test.
   logic signed [COORD_W:0] dx, dy;
   logic                    in_x, in_y;
   logic                    p2_valid_ff;
   side_type                p2_side_ff;
   logic [LW-1:0]           p2_dx_ff, p2_dy_ff;

   assign dx   = {p1_req_ff.point_x[COORD_W-1], p1_req_ff.point_x}
               - {origin_x_ff[COORD_W-1], origin_x_ff};
   assign dy   = {p1_req_ff.point_y[COORD_W-1], p1_req_ff.point_y}
               - {origin_y_ff[COORD_W-1], origin_y_ff};
   assign in_x = !dx[COORD_W] && (CMP_W'(dx[COORD_W-1:0]) <= CMP_W'(lim_x_ff));
   assign in_y = !dy[COORD_W] && (CMP_W'(dy[COORD_W-1:0]) <= CMP_W'(lim_y_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_side_ff.query   <= (p1_req_ff.cmd == CMD_QUERY);
         p2_side_ff.in_grid <= in_x && in_y;
         p2_side_ff.row     <= p1_req_ff.cell_row;
         p2_side_ff.col     <= p1_req_ff.cell_col;
         p2_side_ff.height  <= p1_req_ff.cell_height;
         p2_dx_ff           <= LW'(dx[COORD_W-1:0]);
         p2_dy_ff           <= LW'(dy[COORD_W-1:0]);
      end
   end

   // Dividers: cell index and 8-bit weight per axis.
   logic [QW-1:0] qx, qy;

   bglk_div #(.DXW(LW), .IW(IW)) u_div_x (
      .clock(clock), .en(adv), .dividend(p2_dx_ff), .divisor(sp_eff), .quotient(qx)
   );

   bglk_div #(.DXW(LW), .IW(IW)) u_div_y (
      .clock(clock), .en(adv), .dividend(p2_dy_ff), .divisor(sp_eff), .quotient(qy)
   );

   // Side line that keeps each transaction aligned with its quotients.
   logic     sd_valid_ff [0:Q-1];
   side_type sd_side_ff  [0:Q-1];

   genvar s;
   for (s = 0; s < Q; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            sd_valid_ff[s] <= 1'b0;
         end else if (adv) begin
            sd_valid_ff[s] <= (s == 0) ? p2_valid_ff : sd_valid_ff[(s == 0) ? 0 : s - 1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sd_side_ff[s] <= (s == 0) ? p2_side_ff : sd_side_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   // Grid access stage: four banks split by row and column parity.
   logic              r_valid;
   side_type          r_side;
   logic [CW-1:0]     xa;
   logic [RW-1:0]     ya;
   logic [CW:0]       xa1;
   logic [RW:0]       ya1;
   logic [FRAC_W-1:0] wx, wy;
   logic [31:0]       wr_row32, wr_col32;
   logic              wr_ok;
   logic [BAW-1:0]    wr_addr;
   logic [BAW-1:0]    rd_addr [0:3];
   logic              wr_en   [0:3];
   logic [HGT_W-1:0]  rd_data [0:3];

   assign r_valid = sd_valid_ff[Q-1];
   assign r_side  = sd_side_ff[Q-1];
   assign xa      = qx[FRAC_W +: CW];
   assign ya      = qy[FRAC_W +: RW];
   assign wx      = qx[FRAC_W-1:0];
   assign wy      = qy[FRAC_W-1:0];
   assign xa1     = {1'b0, xa} + (CW+1)'(1);
   assign ya1     = {1'b0, ya} + (RW+1)'(1);

   assign wr_row32 = 32'(r_side.row);
   assign wr_col32 = 32'(r_side.col);
   assign wr_ok    = adv && r_valid && !r_side.query
                  && (wr_row32 < MAX_ROWS) && (wr_col32 < MAX_COLS);
   assign wr_addr  = {HRW'(wr_row32 >> 1), HCW'(wr_col32 >> 1)};

   genvar b;
   for (b = 0; b < 4; b++) begin : g_bank
      localparam logic [1:0] BSEL = 2'(b);
      logic [CW:0] col_sel;
      logic [RW:0] row_sel;

      // Each bank serves the corner whose row and column parity match it.
      assign col_sel = (xa[0] == BSEL[0]) ? {1'b0, xa} : xa1;
      assign row_sel = (ya[0] == BSEL[1]) ? {1'b0, ya} : ya1;
      assign rd_addr[b] = {HRW'(row_sel >> 1), HCW'(col_sel >> 1)};
      assign wr_en[b]   = wr_ok && (r_side.row[0] == BSEL[1]) && (r_side.col[0] == BSEL[0]);

      bglk_bank #(.AW(BAW), .DW(HGT_W)) u_bank (
         .clock(clock), .rd_en(adv), .rd_addr(rd_addr[b]), .rd_data(rd_data[b]),
         .wr_en(wr_en[b]), .wr_addr(wr_addr), .wr_data(r_side.height)
      );
   end

   // Stage after the grid read.
   logic              pd_valid_ff;
   logic              pd_inside_ff, pd_xp_ff, pd_yp_ff;
   logic [FRAC_W-1:0] pd_wx_ff, pd_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pd_valid_ff <= 1'b0;
      end else if (adv) begin
         pd_valid_ff <= r_valid && r_side.query;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pd_inside_ff <= r_side.in_grid;
         pd_xp_ff     <= xa[0];
         pd_yp_ff     <= ya[0];
         pd_wx_ff     <= wx;
         pd_wy_ff     <= wy;
      end
   end

   // Row blend products. A corner with zero weight is forced to zero.
   logic signed [HGT_W-1:0]  h_aa, h_ab, h_ba, h_bb;
   logic [FRAC_W:0]          wxc, wyc;
   logic                     m1_valid_ff, m1_inside_ff;
   logic [FRAC_W-1:0]        m1_wy_ff;
   logic signed [HGT_W+9:0]  m1_paa_ff, m1_pab_ff, m1_pba_ff, m1_pbb_ff;

   assign h_aa = rd_data[{pd_yp_ff, pd_xp_ff}];
   assign h_ab = (pd_wx_ff != '0) ? rd_data[{pd_yp_ff, !pd_xp_ff}] : '0;
   assign h_ba = (pd_wy_ff != '0) ? rd_data[{!pd_yp_ff, pd_xp_ff}] : '0;
   assign h_bb = (pd_wx_ff != '0 && pd_wy_ff != '0)
               ? rd_data[{!pd_yp_ff, !pd_xp_ff}] : '0;
   assign wxc  = (FRAC_W+1)'(256) - {1'b0, pd_wx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= pd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_inside_ff <= pd_inside_ff;
         m1_wy_ff     <= pd_wy_ff;
         m1_paa_ff    <= h_aa * $signed({1'b0, wxc});
         m1_pab_ff    <= h_ab * $signed({2'b0, pd_wx_ff});
         m1_pba_ff    <= h_ba * $signed({1'b0, wxc});
         m1_pbb_ff    <= h_bb * $signed({2'b0, pd_wx_ff});
      end
   end

   // Row sums.
   logic                     m2_valid_ff, m2_inside_ff;
   logic [FRAC_W-1:0]        m2_wy_ff;
   logic signed [HGT_W+10:0] m2_top_ff, m2_bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_inside_ff <= m1_inside_ff;
         m2_wy_ff     <= m1_wy_ff;
         m2_top_ff    <= (HGT_W+11)'(m1_paa_ff) + (HGT_W+11)'(m1_pab_ff);
         m2_bot_ff    <= (HGT_W+11)'(m1_pba_ff) + (HGT_W+11)'(m1_pbb_ff);
      end
   end

   // Column blend products.
   logic                     m3_valid_ff, m3_inside_ff;
   logic signed [HGT_W+20:0] m3_top_ff, m3_bot_ff;

   assign wyc = (FRAC_W+1)'(256) - {1'b0, m2_wy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (adv) begin
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_inside_ff <= m2_inside_ff;
         m3_top_ff    <= m2_top_ff * $signed({1'b0, wyc});
         m3_bot_ff    <= m2_bot_ff * $signed({2'b0, m2_wy_ff});
      end
   end

   // Final sum, truncated toward zero, and the outside case.
   logic signed [HGT_W+21:0] v_sum, v_adj;
   rsp_type                  res_in;
   logic                     res_new;

   assign v_sum = (HGT_W+22)'(m3_top_ff) + (HGT_W+22)'(m3_bot_ff);
   assign v_adj = v_sum + (v_sum[HGT_W+21] ? (HGT_W+22)'(16'hFFFF) : '0);

   always_comb begin
      res_in.inside_res = m3_inside_ff;
      res_in.height_out = m3_inside_ff ? v_adj[16 +: HGT_W] : '0;
   end

   assign res_new = adv && m3_valid_ff;

   // ---------------------------------------------------------------- output and skid
   logic    rsp_valid_ff, rsp_take;
   rsp_type rsp_data_ff, skid_data_ff;

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (res_new) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (res_new) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_data_ff <= res_in;
         end else begin
            skid_data_ff <= res_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   `BGHL_ASSERT_IMPL(a_skid_needs_out, skid_valid_ff, rsp_valid_ff)
   `BGHL_ASSERT_NEXT(a_skid_drains, skid_valid_ff && !rsp_stall, rsp_valid_ff && !skid_valid_ff)
   `BGHL_ASSERT_IMPL(a_outside_zero, rsp_valid_ff && !rsp_data_ff.inside_res, rsp_data_ff.height_out == '0)
   `BGHL_ASSERT_IMPL(a_write_only_moving, wr_ok, adv && !req_stall)

endmodule

[verif/tb.sv]
// Testbench for the bilinear grid height lookup: directed and random transactions
// checked against an in-bench predictor of the interpolation. Depends on bglk_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import bglk_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int GRID_COLS      = 64;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   // Predictor state: grid copy, written flags and register copies.
   logic signed [HGT_W-1:0] grid_copy [0:4095];
   bit                      cell_written [0:4095];
   logic signed [31:0]      org_x, org_y;
   logic [23:0]             spacing;
   logic [6:0]              cols_reg, rows_reg;

   rsp_type pending_heights [$];
   int      mismatches;
   int      send_idle_pct;
   int      stall_pct;
   int      hold_left;
   int      quiet_cycles;

   bilinear_grid_height_lookup dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic longint eff_count(input logic [6:0] n);
      if (n < 2) return 2;
      if (n > GRID_COLS) return GRID_COLS;
      return longint'(n);
   endfunction

   function automatic longint eff_spacing();
      return (spacing == 0) ? 1 : longint'(spacing);
   endfunction

   // Locate one axis; returns 0 when the point is outside the grid.
   function automatic bit locate(input longint p, input longint org, input longint n,
                                 input longint sp, output longint lo, output longint hi,
                                 output longint wt);
      longint d;
      d = p - org;
      if (d < 0) return 0;
      if (d > (n - 1) * sp) return 0;
      lo = d / sp;
      wt = ((d % sp) * 256) / sp;
      hi = (lo + 1 < n) ? lo + 1 : n - 1;
      return 1;
   endfunction

   function automatic rsp_type interpolate(input logic signed [31:0] px,
                                           input logic signed [31:0] py);
      rsp_type r;
      longint xa, xb, xw, ya, yb, yw, top, bot, v, res;
      r = '0;
      if (!locate(longint'(px), longint'(org_x), eff_count(cols_reg), eff_spacing(),
                  xa, xb, xw) ||
          !locate(longint'(py), longint'(org_y), eff_count(rows_reg), eff_spacing(),
                  ya, yb, yw))
         return r;
      top = longint'(grid_copy[ya*GRID_COLS+xa]) * (256 - xw)
          + longint'(grid_copy[ya*GRID_COLS+xb]) * xw;
      bot = longint'(grid_copy[yb*GRID_COLS+xa]) * (256 - xw)
          + longint'(grid_copy[yb*GRID_COLS+xb]) * xw;
      v = top * (256 - yw) + bot * yw;
      res = (v < 0) ? -((-v) >>> 16) : (v >>> 16);
      r.height_out = res[HGT_W-1:0];
      r.inside_res = 1'b1;
      return r;
   endfunction

   // Update the predictor with one accepted transaction.
   function automatic void absorb_item(input req_type it);
      if (it.cmd == CMD_WRITE) begin
         grid_copy[{it.cell_row, it.cell_col}] = it.cell_height;
         cell_written[{it.cell_row, it.cell_col}] = 1'b1;
      end else begin
         pending_heights.insert(pending_heights.size(), interpolate(it.point_x, it.point_y));
      end
   endfunction

   // Offer one transaction, with random idle cycles first; returns at a falling edge.
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_item(it);
      @(negedge clock);
   endtask

   task automatic send_write(input int row, input int col, input logic [23:0] h);
      req_type it;
      it = '0;
      it.cmd = CMD_WRITE;
      it.cell_row = row[5:0];
      it.cell_col = col[5:0];
      it.cell_height = h;
      it.point_x = $urandom;
      it.point_y = $urandom;
      send_item(it);
   endtask

   function automatic logic [23:0] rand_height();
      case ($urandom_range(7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         default: return 24'($urandom);
      endcase
   endfunction

   // Send a query, first writing any corner cell it would read that was never written.
   task automatic send_query(input logic [31:0] px, input logic [31:0] py);
      req_type it;
      longint xa, xb, xw, ya, yb, yw;
      if (locate(longint'($signed(px)), longint'(org_x), eff_count(cols_reg), eff_spacing(),
                 xa, xb, xw) &&
          locate(longint'($signed(py)), longint'(org_y), eff_count(rows_reg), eff_spacing(),
                 ya, yb, yw)) begin
         if (!cell_written[ya*GRID_COLS+xa]) send_write(ya, xa, rand_height());
         if (!cell_written[ya*GRID_COLS+xb]) send_write(ya, xb, rand_height());
         if (!cell_written[yb*GRID_COLS+xa]) send_write(yb, xa, rand_height());
         if (!cell_written[yb*GRID_COLS+xb]) send_write(yb, xb, rand_height());
      end
      it = '0;
      it.cmd = CMD_QUERY;
      it.cell_row = 6'($urandom);
      it.cell_col = 6'($urandom);
      it.cell_height = 24'($urandom);
      it.point_x = px;
      it.point_y = py;
      send_item(it);
   endtask

   function automatic logic [31:0] rand_coord(input logic signed [31:0] org,
                                              input logic [6:0] n);
      longint span, d;
      span = (eff_count(n) - 1) * eff_spacing();
      case ($urandom_range(9))
         0: d = 0;
         1: d = span;
         2: d = longint'($urandom_range(0, int'(eff_count(n) - 1))) * eff_spacing();
         default: d = longint'($urandom_range(0, int'(span)));
      endcase
      return 32'(longint'(org) + d);
   endfunction

   // One random transaction: mostly in-grid queries, some writes, some noise.
   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 20)
         send_write($urandom_range(0, int'(eff_count(rows_reg)) - 1),
                    $urandom_range(0, int'(eff_count(cols_reg)) - 1), rand_height());
      else if (pick < 25)
         send_write($urandom_range(63), $urandom_range(63), rand_height());
      else if (pick < 40)
         send_query($urandom, $urandom);
      else if (pick < 45)
         send_query(rand_coord(org_x, cols_reg), $urandom);
      else
         send_query(rand_coord(org_x, cols_reg), rand_coord(org_y, rows_reg));
   endtask

   // Register write over the APB port; only called while the block is idle.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = CSR_AW'({idx, 2'b00});
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      case (idx)
         REG_ORIGIN_X: org_x = value;
         REG_ORIGIN_Y: org_y = value;
         REG_SPACING:  spacing = value[23:0];
         REG_COLUMNS:  cols_reg = value[6:0];
         REG_ROWS:     rows_reg = value[6:0];
         default: ;
      endcase
   endtask

   // Wait for every expected result, then let the pipeline empty out.
   task automatic drain();
      req_valid = 1'b0;
      while (pending_heights.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] sp, input logic [31:0] nc,
                           input logic [31:0] nr);
      drain();
      csr_write(REG_ORIGIN_X, ox);
      csr_write(REG_ORIGIN_Y, oy);
      csr_write(REG_SPACING, sp);
      csr_write(REG_COLUMNS, nc);
      csr_write(REG_ROWS, nr);
   endtask

   // Field extremes, grid edges and both commands on a small grid.
   task automatic test_directed();
      set_grid(32'd0, 32'd0, 32'd256, 32'd3, 32'd3);
      send_write(0, 0, 24'h7FFFFF);
      send_write(0, 1, 24'h800000);
      send_write(0, 2, 24'h000000);
      send_write(1, 0, 24'h800000);
      send_write(1, 1, 24'h7FFFFF);
      send_write(1, 2, 24'hFFFFFF);
      send_write(2, 0, 24'h000001);
      send_write(2, 1, 24'h7FFFFF);
      send_write(2, 2, 24'h800000);
      send_query(32'd0, 32'd0);
      send_query(32'd512, 32'd512);
      send_query(32'd511, 32'd1);
      send_query(32'd128, 32'd384);
      send_query(32'd255, 32'd255);
      send_query(32'd513, 32'd0);
      send_query(32'hFFFFFFFF, 32'd0);
      send_query(32'd0, 32'd513);
      send_query(32'd0, 32'hFFFFFFFF);
      send_query(32'h7FFFFFFF, 32'h7FFFFFFF);
      send_query(32'h80000000, 32'h80000000);
      send_query(32'd512, 32'd100);
      send_query(32'd300, 32'd512);
   endtask

   // Register settings including extremes and the clamped special values.
   task automatic test_config_sweep();
      set_grid(32'h80000000, 32'h7FFFF000, 32'd1, 32'd64, 32'd0);
      repeat (40) random_item();
      set_grid(32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd127, 32'd1);
      repeat (40) random_item();
      set_grid(32'hC0000000, 32'hC0000000, 32'hFFFFFF, 32'd2, 32'd64);
      repeat (40) random_item();
      set_grid(32'hFFFFFF00, 32'd100, 32'd1000, 32'd1, 32'd127);
      repeat (40) random_item();
      set_grid($urandom, $urandom, $urandom_range(1, 5000), $urandom_range(2, 9),
               $urandom_range(2, 9));
      repeat (40) random_item();
   endtask

   // Random traffic under each idling mix.
   task automatic test_idle_mixes();
      int mode;
      for (mode = 0; mode < 4; mode++) begin
         drain();
         send_idle_pct = (mode == 1) ? 78 : (mode == 3) ? 30 : 0;
         stall_pct     = (mode == 2) ? 78 : (mode == 3) ? 30 : 0;
         set_grid($urandom, $urandom, $urandom_range(1, 100000), $urandom_range(2, 12),
                  $urandom_range(2, 12));
         repeat (120) random_item();
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   // Receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      drain();
      set_grid(32'd0, 32'd0, 32'd256, 32'd4, 32'd4);
      hold_left = 300;
      repeat (100) random_item();
   endtask

   // Receiver: stall pattern driven at the falling edge.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_heights.size() == 0) begin
            $display("%0t: unexpected result height=%h inside=%b", $time,
                     rsp_data.height_out, rsp_data.inside_res);
            mismatches++;
         end else begin
            want = pending_heights.pop_front();
            if (want.height_out !== rsp_data.height_out) begin
               $display("%0t: height_out expected %h actual %h", $time,
                        want.height_out, rsp_data.height_out);
               mismatches++;
            end
            if (want.inside_res !== rsp_data.inside_res) begin
               $display("%0t: inside_res expected %b actual %b", $time,
                        want.inside_res, rsp_data.inside_res);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      paddr = '0; pwdata = '0;
      mismatches = 0; send_idle_pct = 0; stall_pct = 0; hold_left = 0;
      quiet_cycles = 0;
      org_x = 0; org_y = 0; spacing = 24'd256; cols_reg = 7'd2; rows_reg = 7'd2;
      for (int i = 0; i < 4096; i++) begin
         grid_copy[i] = '0;
         cell_written[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_sweep();
      test_idle_mixes();
      test_backpressure();
      drain();
      if (mismatches == 0 && pending_heights.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
